// ===== design/lfpd_pkg.sv =====
`timescale 1ns / 1ps

package lfpd_pkg;

    localparam int DRIVE_W = 8;
    localparam int GAIN_W = 16;
    localparam int SUM_W = 32;
    localparam int QUOT_W = 10;
    localparam int TERM_SHIFT = 16;
    localparam int KP_OFFSET = 1000;
    localparam int unsigned DIVISOR = 32'd65536000;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN = 2'd2;

    localparam int THRESHOLD_RESET = 2048;
    localparam logic [DRIVE_W-1:0] BASE_RESET = 8'd240;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd0;

    localparam int OUT_DATA_W = 2 * DRIVE_W;
    localparam int OUT_USER_W = 2;
    localparam int USER_TRACKING = 0;
    localparam int USER_STOPPED = 1;

endpackage

// ===== design/line_follow_pid_drive.sv =====
`timescale 1ns / 1ps

// Line follower with a gain-scheduled PID step for a differential drive.
// Input stream: s_tdata carries the left, centre and right light samples,
// s_tuser carries the stop flag. Result stream: m_tdata carries the left and
// right drive levels, m_tuser the tracking and stopped flags. Every request
// gives exactly one result. The APB port sets the centre threshold, the base
// speed and the integral gain; writes must be made while the block is idle,
// which the block itself does not enforce. A stopped or held request goes
// from IDLE straight to DONE, where its result is registered. A PID step
// uses the shift-add multiplier, one multiplier bit a cycle, SAMPLE_BITS + 6
// bits for the proportional and derivative term and 32 bits for the integral
// term, then a restoring divider retires one of the 10 quotient bits a cycle.
// One request is processed at a time; s_tready is high while the sequencer
// is idle, also while a finished result still waits in the output register.
// A new request is taken only after the previous one has left DONE for IDLE.
// When the receiver stalls the result is held and the next request may be
// taken and worked on, but it waits until the output register is free.
// Reset clears the PID history and the held drives and restores the register
// defaults; no result is valid after reset.

module line_follow_pid_drive #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // sample_left, sample_center, sample_right, zero padding
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // stop_request
    input  logic [0:0] s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // left_drive, right_drive
    output logic [lfpd_pkg::OUT_DATA_W-1:0] m_tdata,
    // tracking, stopped
    output logic [lfpd_pkg::OUT_USER_W-1:0] m_tuser,

    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [lfpd_pkg::APB_AW-1:0] paddr,
    input  logic [lfpd_pkg::APB_DW-1:0] pwdata,
    output logic [lfpd_pkg::APB_DW-1:0] prdata,
    output logic pready
);

    localparam int S = SAMPLE_BITS;
    localparam int TW = (S > 12) ? S : 12;
    localparam int EW = S + 1;
    localparam int DW = S + 2;
    localparam int PW = S + 6;
    localparam int KW = ((S > 10) ? S : 10) + 2;
    localparam int K6W = KW + 3;
    localparam int GW = lfpd_pkg::GAIN_W + 10;
    localparam int T1W = K6W + PW + lfpd_pkg::TERM_SHIFT;
    localparam int T2W = lfpd_pkg::GAIN_W + lfpd_pkg::SUM_W + 10;
    localparam int NW = ((T1W > T2W) ? T1W : T2W) + 1;
    localparam int SW = lfpd_pkg::SUM_W;
    localparam int CW = $clog2(SW);
    localparam int QW = lfpd_pkg::QUOT_W;
    localparam int DRW = lfpd_pkg::DRIVE_W;
    localparam int CLW = DRW + 4;

    localparam logic [NW-1:0] DIV_TOP = NW'(lfpd_pkg::DIVISOR) << (QW - 1);
    localparam logic [NW-1:0] DIV_SAT = NW'(lfpd_pkg::DIVISOR) << QW;
    localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [2:0] {
        IDLE,
        MUL_P,
        MUL_I,
        ABS,
        DIV,
        DONE
    } state_t;

    state_t state_reg;

    logic [TW-1:0] threshold_reg;
    logic [DRW-1:0] base_reg;
    logic [lfpd_pkg::GAIN_W-1:0] gain_reg;

    logic [EW-1:0] prior_error_reg;
    logic [SW-1:0] error_sum_reg;
    logic [DRW-1:0] held_left_reg;
    logic [DRW-1:0] held_right_reg;

    logic stop_reg;
    logic track_reg;
    logic [DRW-1:0] res_left_reg;
    logic [DRW-1:0] res_right_reg;

    logic [SW-1:0] mplier_reg;
    logic [NW-1:0] mcand_reg;
    logic [NW-1:0] acc_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dv_reg;
    logic [QW-1:0] quot_reg;
    logic neg_reg;
    logic sat_reg;

    logic m_tvalid_reg;
    logic [lfpd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [lfpd_pkg::OUT_USER_W-1:0] m_tuser_reg;

    logic [S-1:0] sample_left;
    logic [S-1:0] sample_center;
    logic [S-1:0] sample_right;
    logic stop_request;

    logic signed [EW-1:0] err;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] diff_x;
    logic signed [PW-1:0] pd_term;
    logic signed [KW-1:0] kc;
    logic signed [K6W-1:0] kc_x;
    logic signed [K6W-1:0] kc6;
    logic signed [GW-1:0] gain_x;
    logic signed [GW-1:0] gain1000;
    logic [SW:0] sum_wide;
    logic [SW-1:0] sum_next;
    logic run_pid;

    logic [NW-1:0] addend;
    logic [NW-1:0] acc_next;
    logic [NW-1:0] acc_abs;
    logic mul_last;

    logic [QW-1:0] quot_mag;
    logic signed [CLW-1:0] pid;
    logic signed [CLW-1:0] left_raw;
    logic signed [CLW-1:0] right_raw;
    logic [DRW-1:0] left_clamped;
    logic [DRW-1:0] right_clamped;
    logic [DRW-1:0] left_out;
    logic [DRW-1:0] right_out;

    logic cfg_write;
    logic [lfpd_pkg::REG_IDX_W-1:0] cfg_idx;

    function automatic logic [DRW-1:0] clamp_drive(input logic signed [CLW-1:0] v);
        logic [DRW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > CLW'(2**DRW - 1)) begin
            r = '1;
        end else begin
            r = v[DRW-1:0];
        end
        return r;
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[lfpd_pkg::APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= TW'(lfpd_pkg::THRESHOLD_RESET);
            base_reg <= lfpd_pkg::BASE_RESET;
            gain_reg <= lfpd_pkg::GAIN_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                lfpd_pkg::REG_THRESHOLD: threshold_reg <= TW'(pwdata[S-1:0]);
                lfpd_pkg::REG_BASE: base_reg <= pwdata[DRW-1:0];
                lfpd_pkg::REG_GAIN: gain_reg <= pwdata[lfpd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lfpd_pkg::REG_THRESHOLD: prdata = lfpd_pkg::APB_DW'(threshold_reg);
            lfpd_pkg::REG_BASE: prdata = lfpd_pkg::APB_DW'(base_reg);
            lfpd_pkg::REG_GAIN: prdata = lfpd_pkg::APB_DW'(gain_reg);
            default: prdata = '0;
        endcase
    end

    // Request fields and the terms prepared at acceptance.
    assign sample_left = s_tdata[S-1:0];
    assign sample_center = s_tdata[2*S-1:S];
    assign sample_right = s_tdata[3*S-1:2*S];
    assign stop_request = s_tuser[0];

    assign err = EW'(sample_left) - EW'(sample_right);
    assign diff = DW'(err) - DW'($signed(prior_error_reg));
    assign diff_x = PW'(diff);
    assign pd_term = PW'(err) + (diff_x <<< 3) + (diff_x <<< 1);
    assign kc = KW'(lfpd_pkg::KP_OFFSET) - KW'(sample_center);
    assign kc_x = K6W'(kc);
    assign kc6 = (kc_x <<< 2) + (kc_x <<< 1);
    assign gain_x = GW'($signed(gain_reg));
    assign gain1000 = (gain_x <<< 10) - (gain_x <<< 4) - (gain_x <<< 3);

    assign sum_wide = (SW+1)'($signed(error_sum_reg)) + (SW+1)'(err);
    always_comb begin
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_next = sum_wide[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SW-1:0];
        end
    end

    assign run_pid = !stop_request && (TW'(sample_center) < threshold_reg);

    // Shift-add step: the multiplier's top bit carries negative weight.
    assign mul_last = (state_reg == MUL_P) ? (cnt_reg == CW'(PW - 1))
                                           : (cnt_reg == CW'(SW - 1));
    assign addend = mplier_reg[0] ? mcand_reg : '0;
    assign acc_next = mul_last ? (acc_reg - addend) : (acc_reg + addend);
    assign acc_abs = acc_reg[NW-1] ? (NW'(0) - acc_reg) : acc_reg;

    // Correction and clamping of the drives.
    assign quot_mag = sat_reg ? '1 : quot_reg;
    assign pid = neg_reg ? (CLW'(0) - CLW'(quot_mag)) : CLW'(quot_mag);
    assign left_raw = CLW'(base_reg) - pid;
    assign right_raw = CLW'(base_reg) + pid;
    assign left_clamped = clamp_drive(left_raw);
    assign right_clamped = clamp_drive(right_raw);
    assign left_out = track_reg ? left_clamped : res_left_reg;
    assign right_out = track_reg ? right_clamped : res_right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_tvalid_reg <= 1'b0;
            prior_error_reg <= '0;
            error_sum_reg <= '0;
            held_left_reg <= '0;
            held_right_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        stop_reg <= stop_request;
                        track_reg <= run_pid;
                        res_left_reg <= stop_request ? '0 : held_left_reg;
                        res_right_reg <= stop_request ? '0 : held_right_reg;
                        if (run_pid) begin
                            prior_error_reg <= err;
                            error_sum_reg <= sum_next;
                            mplier_reg <= SW'(pd_term);
                            mcand_reg <= NW'(kc6) << lfpd_pkg::TERM_SHIFT;
                            acc_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= MUL_P;
                        end else begin
                            state_reg <= DONE;
                        end
                    end
                end
                MUL_P: begin
                    acc_reg <= acc_next;
                    if (mul_last) begin
                        mplier_reg <= error_sum_reg;
                        mcand_reg <= NW'(gain1000);
                        cnt_reg <= '0;
                        state_reg <= MUL_I;
                    end else begin
                        mplier_reg <= mplier_reg >> 1;
                        mcand_reg <= mcand_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MUL_I: begin
                    acc_reg <= acc_next;
                    mplier_reg <= mplier_reg >> 1;
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (mul_last) begin
                        state_reg <= ABS;
                    end
                end
                ABS: begin
                    rem_reg <= acc_abs;
                    neg_reg <= acc_reg[NW-1];
                    sat_reg <= acc_abs >= DIV_SAT;
                    dv_reg <= DIV_TOP;
                    quot_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= DIV;
                end
                DIV: begin
                    if (rem_reg >= dv_reg) begin
                        rem_reg <= rem_reg - dv_reg;
                        quot_reg <= {quot_reg[QW-2:0], 1'b1};
                    end else begin
                        quot_reg <= {quot_reg[QW-2:0], 1'b0};
                    end
                    dv_reg <= dv_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(QW - 1)) begin
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {right_out, left_out};
                        m_tuser_reg <= {stop_reg, track_reg};
                        held_left_reg <= left_out;
                        held_right_reg <= right_out;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== design/lfpd_checker.sv =====
`timescale 1ns / 1ps

module lfpd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [lfpd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [lfpd_pkg::OUT_USER_W-1:0] m_tuser
);

    logic [1:0] pending_reg;
    logic s_acc;
    logic m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (s_acc && !m_acc) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (m_acc && !s_acc) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A stopped result always drives both motors to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[lfpd_pkg::USER_STOPPED] |-> m_tdata == '0)
        else $error("stopped result with nonzero drive");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[lfpd_pkg::USER_TRACKING] && m_tuser[lfpd_pkg::USER_STOPPED]))
        else $error("result both tracking and stopped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // At most one request in work and one result waiting, and no result without a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3 && (!m_tvalid || pending_reg != 2'd0))
        else $error("requests and results out of step");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (.*);
